### rtl/core/miller_rabin_primality_test_macros.svh
// Assertion macros for the Miller-Rabin block.
// Included by the top level; needs clk_i and rst_ni in scope.
`ifndef MILLER_RABIN_PRIMALITY_TEST_MACROS_SVH
`define MILLER_RABIN_PRIMALITY_TEST_MACROS_SVH
`define MR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
`define MR_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);
`endif

### rtl/core/mrpt_pkg.sv
// Package for the Miller-Rabin block: transaction payload types and commands.
// No dependencies.
package mrpt_pkg;
  localparam int unsigned FieldW = 32;

  typedef struct packed {
    logic [FieldW-1:0] candidate;
    logic [FieldW-1:0] witness;
    logic              last_round;
  } mrpt_in_t;

  typedef struct packed {
    logic composite;
    logic run_end;
  } mrpt_out_t;

  typedef enum logic [2:0] {
    CmdNone,
    CmdLoad,
    CmdReduce,
    CmdPowMul,
    CmdPowSqr,
    CmdSqr
  } mrpt_cmd_e;

  typedef struct packed {
    logic mul_busy;
    logic small_comp;
    logic is_two;
    logic red_done;
    logic a_zero;
    logic exp_zero;
    logic exp_bit;
    logic x_one;
    logic x_nm1;
    logic s_done;
  } mrpt_status_t;
endpackage

### rtl/core/miller_rabin_primality_test.sv
// Top level of the Miller-Rabin block: controller plus datapath.
// Depends on mrpt_pkg, mrpt_ctrl, mrpt_datapath and the macros header.
// One round per transaction. A round takes up to about 2 * NumWidth modular
// multiplications in the bit-serial multiplier, plus a bit-serial reduction of
// the witness while n-1 is factored, and the control steps; far less work for
// small or even candidates. The result waits in an output register.
`include "miller_rabin_primality_test_macros.svh"
module miller_rabin_primality_test import mrpt_pkg::*; #(
  parameter int unsigned NumWidth = 32
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  mrpt_in_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output mrpt_out_t out_data_o
);
  mrpt_cmd_e    cmd;
  mrpt_status_t st;

  mrpt_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .last_i(in_data_i.last_round), .in_stall_o,
    .out_stall_i, .out_valid_o, .out_o(out_data_o), .cmd_o(cmd), .st_i(st)
  );

  mrpt_datapath #(.NumWidth(NumWidth)) u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .item_i(in_data_i), .status_o(st)
  );

  `MR_ASSERT_NEXT(a_accept_stalls, in_valid_i && !in_stall_o, in_stall_o,
    "input accepted while a round was in progress")
  `MR_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i,
    out_valid_o && $stable(out_data_o), "stalled result changed")
  `MR_ASSERT(a_no_cmd_busy, !(st.mul_busy && cmd != CmdNone),
    "command issued while multiplier busy")
endmodule

### rtl/core/mrpt_datapath.sv
// Datapath of the Miller-Rabin block: operand registers and a shift-add modular
// multiplier that handles one multiplier bit per cycle. Depends on mrpt_pkg.
module mrpt_datapath import mrpt_pkg::*; #(
  parameter int unsigned NumWidth = 32
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  mrpt_cmd_e        cmd_i,
  input  mrpt_in_t         item_i,
  output mrpt_status_t     status_o
);
  localparam int unsigned CntW = $clog2(NumWidth + 1);

  logic [NumWidth-1:0] n_q, n_d, a_q, a_d, x_q, x_d, e_q, e_d, nm1;
  logic [CntW-1:0]     s_q, s_d;
  logic [NumWidth-1:0] mx_q, mx_d, my_q, my_d, acc_q, acc_d;
  logic [CntW-1:0]     mcnt_q, mcnt_d;
  logic                mbusy_q, mbusy_d, mdst_q, mdst_d;
  logic [NumWidth:0]   dbl, sum;
  logic [NumWidth-1:0] dbl_r, sum_r, nm1_t;
  logic [NumWidth-1:0] cand, wit;
  logic [NumWidth-1:0] wsh_q, wsh_d, rem_r;
  logic [NumWidth:0]   rem_t;
  logic [CntW-1:0]     rcnt_q, rcnt_d;

  assign cand  = NumWidth'(item_i.candidate);
  assign wit   = NumWidth'(item_i.witness);
  assign nm1   = n_q - NumWidth'(1);
  assign dbl   = {1'b0, acc_q} + {1'b0, acc_q};
  assign dbl_r = (dbl >= {1'b0, n_q}) ? NumWidth'(dbl - {1'b0, n_q}) : dbl[NumWidth-1:0];
  assign sum   = {1'b0, dbl_r} + {1'b0, mx_q};
  assign sum_r = (sum >= {1'b0, n_q}) ? NumWidth'(sum - {1'b0, n_q}) : sum[NumWidth-1:0];
  assign nm1_t = cand - NumWidth'(1);
  assign rem_t = {a_q, wsh_q[NumWidth-1]};
  assign rem_r = (rem_t >= {1'b0, n_q}) ? NumWidth'(rem_t - {1'b0, n_q}) :
                 rem_t[NumWidth-1:0];

  always_comb begin
    n_d = n_q; a_d = a_q; x_d = x_q; e_d = e_q; s_d = s_q;
    mx_d = mx_q; my_d = my_q; acc_d = acc_q; mcnt_d = mcnt_q;
    mbusy_d = mbusy_q; mdst_d = mdst_q;
    wsh_d = wsh_q; rcnt_d = rcnt_q;
    if (mbusy_q) begin
      acc_d  = my_q[NumWidth-1] ? sum_r : dbl_r;
      my_d   = my_q << 1;
      mcnt_d = mcnt_q - CntW'(1);
      if (mcnt_q == CntW'(1)) begin
        mbusy_d = 1'b0;
        if (mdst_q) a_d = acc_d;
        else        x_d = acc_d;
      end
    end else begin
      unique case (cmd_i)
        CmdLoad: begin
          n_d = cand; a_d = '0; x_d = NumWidth'(1);
          e_d = nm1_t; s_d = '0;
          wsh_d = wit; rcnt_d = CntW'(NumWidth);
        end
        CmdReduce: begin
          if (e_q[0] == 1'b0 && e_q != '0) begin
            e_d = e_q >> 1; s_d = s_q + CntW'(1);
          end
          if (rcnt_q != '0) begin
            a_d = rem_r; wsh_d = wsh_q << 1; rcnt_d = rcnt_q - CntW'(1);
          end
        end
        CmdPowMul: begin
          mx_d = x_q; my_d = a_q; acc_d = '0; mcnt_d = CntW'(NumWidth);
          mbusy_d = 1'b1; mdst_d = 1'b0;
        end
        CmdPowSqr: begin
          mx_d = a_q; my_d = a_q; acc_d = '0; mcnt_d = CntW'(NumWidth);
          mbusy_d = 1'b1; mdst_d = 1'b1; e_d = e_q >> 1;
        end
        CmdSqr: begin
          mx_d = x_q; my_d = x_q; acc_d = '0; mcnt_d = CntW'(NumWidth);
          mbusy_d = 1'b1; mdst_d = 1'b0; s_d = s_q - CntW'(1);
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mbusy_q <= 1'b0;
      mcnt_q  <= '0;
    end else begin
      mbusy_q <= mbusy_d;
      mcnt_q  <= mcnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    n_q <= n_d; a_q <= a_d; x_q <= x_d; e_q <= e_d; s_q <= s_d;
    mx_q <= mx_d; my_q <= my_d; acc_q <= acc_d; mdst_q <= mdst_d;
    wsh_q <= wsh_d; rcnt_q <= rcnt_d;
  end

  assign status_o.mul_busy   = mbusy_q;
  assign status_o.small_comp = (n_q < NumWidth'(2)) || (n_q[0] == 1'b0 && n_q != NumWidth'(2));
  assign status_o.is_two     = (n_q == NumWidth'(2));
  assign status_o.red_done   = e_q[0] && (rcnt_q == '0);
  assign status_o.a_zero     = (a_q == '0);
  assign status_o.exp_zero   = (e_q == '0);
  assign status_o.exp_bit    = e_q[0];
  assign status_o.x_one      = (x_q == NumWidth'(1));
  assign status_o.x_nm1      = (x_q == nm1);
  assign status_o.s_done     = (s_q <= CntW'(1));
endmodule

### rtl/core/mrpt_ctrl.sv
// Controller of the Miller-Rabin block: sequences one round and keeps the
// sticky verdict and the output register. Depends on mrpt_pkg.
module mrpt_ctrl import mrpt_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         in_valid_i,
  input  logic         last_i,
  output logic         in_stall_o,
  input  logic         out_stall_i,
  output logic         out_valid_o,
  output mrpt_out_t    out_o,
  output mrpt_cmd_e    cmd_o,
  input  mrpt_status_t st_i
);
  typedef enum logic [2:0] {
    Idle, Check, Reduce, PowStep, PowWait, SqrStep, SqrWait, Finish
  } state_e;

  state_e    state_q;
  logic      last_q, seen_q, verdict_q, ovalid_q, pow_sqr_q;
  mrpt_out_t out_q;
  logic      busy;

  assign busy        = (state_q != Idle);
  assign in_stall_o  = busy || (ovalid_q && out_stall_i);
  assign out_valid_o = ovalid_q;
  assign out_o       = out_q;

  always_comb begin
    cmd_o = CmdNone;
    unique case (state_q)
      Idle:    if (in_valid_i && !in_stall_o) cmd_o = CmdLoad;
      Reduce:  if (!st_i.red_done) cmd_o = CmdReduce;
      PowStep: if (!st_i.exp_zero) cmd_o = st_i.exp_bit && !pow_sqr_q ? CmdPowMul : CmdPowSqr;
      SqrStep: if (!st_i.s_done) cmd_o = CmdSqr;
      default: cmd_o = CmdNone;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= Idle; last_q <= 1'b0; seen_q <= 1'b0; verdict_q <= 1'b0;
      ovalid_q <= 1'b0; out_q <= '0; pow_sqr_q <= 1'b0;
    end else begin
      if (state_q == Finish && (!ovalid_q || !out_stall_i)) ovalid_q <= 1'b1;
      else if (!out_stall_i) ovalid_q <= 1'b0;
      unique case (state_q)
        Idle: if (in_valid_i && !in_stall_o) begin
          last_q <= last_i; state_q <= Check;
        end
        Check: begin
          if (st_i.small_comp) begin
            verdict_q <= 1'b1; state_q <= Finish;
          end else if (st_i.is_two) begin
            verdict_q <= 1'b0; state_q <= Finish;
          end else state_q <= Reduce;
        end
        Reduce: if (st_i.red_done) begin
          // Held here until d is odd and the witness has been reduced below n.
          if (st_i.a_zero) begin
            verdict_q <= 1'b0; state_q <= Finish;
          end else begin
            state_q <= PowStep; pow_sqr_q <= 1'b0;
          end
        end
        PowStep: begin
          if (st_i.exp_zero) begin
            if (st_i.x_one || st_i.x_nm1) begin
              verdict_q <= 1'b0; state_q <= Finish;
            end else state_q <= SqrStep;
          end else begin
            pow_sqr_q <= st_i.exp_bit && !pow_sqr_q;
            state_q <= PowWait;
          end
        end
        PowWait: if (!st_i.mul_busy) state_q <= PowStep;
        SqrStep: begin
          if (st_i.s_done) begin
            verdict_q <= 1'b1; state_q <= Finish;
          end else state_q <= SqrWait;
        end
        SqrWait: if (!st_i.mul_busy) begin
          if (st_i.x_one) begin
            verdict_q <= 1'b1; state_q <= Finish;
          end else if (st_i.x_nm1) begin
            verdict_q <= 1'b0; state_q <= Finish;
          end else state_q <= SqrStep;
        end
        Finish: if (!ovalid_q || !out_stall_i) begin
          out_q.composite <= seen_q | verdict_q;
          out_q.run_end   <= last_q;
          seen_q   <= last_q ? 1'b0 : (seen_q | verdict_q);
          state_q  <= Idle;
        end
        default: state_q <= Idle;
      endcase
    end
  end
endmodule

### sim/tb.sv
// Testbench for miller_rabin_primality_test: directed and random Miller-Rabin runs.
// Depends on mrpt_pkg and the RTL top level; predicts each verdict with its own model.
`timescale 1ns / 100ps
module tb;
  import mrpt_pkg::*;

  localparam longint unsigned CycleLimit = 4000000;

  logic      clk_i;
  logic      rst_ni;
  logic      in_valid_i;
  logic      in_stall_o;
  mrpt_in_t  in_data_i;
  logic      out_valid_o;
  logic      out_stall_i;
  mrpt_out_t out_data_o;

  mrpt_out_t       verdict_q[$];
  logic            sticky_composite;
  int unsigned     idle_pct;
  int unsigned     stall_pct;
  int unsigned     errors;
  longint unsigned cycles;

  miller_rabin_primality_test DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  function automatic logic [63:0] mulmod(logic [63:0] x, logic [63:0] y, logic [63:0] n);
    return (x * y) % n;
  endfunction

  function automatic logic round_proves_composite(logic [31:0] cand, logic [31:0] wit);
    logic [63:0] n, d, a, x, e, b, nm1;
    int unsigned s;
    n = cand;
    if (n < 2) return 1'b1;
    if (n == 2) return 1'b0;
    if (!n[0]) return 1'b1;
    nm1 = n - 1;
    d = nm1;
    s = 0;
    while (!d[0]) begin
      d = d >> 1;
      s++;
    end
    a = wit % n;
    if (a == 0) return 1'b0;
    x = 1;
    b = a;
    e = d;
    while (e != 0) begin
      if (e[0]) x = mulmod(x, b, n);
      b = mulmod(b, b, n);
      e = e >> 1;
    end
    if (x == 1 || x == nm1) return 1'b0;
    for (int j = 1; j < s; j++) begin
      x = mulmod(x, x, n);
      if (x == 1) return 1'b1;
      if (x == nm1) return 1'b0;
    end
    return 1'b1;
  endfunction

  task automatic send_round(logic [31:0] cand, logic [31:0] wit, logic last);
    mrpt_in_t  item;
    mrpt_out_t verdict;
    item.candidate  = cand;
    item.witness    = wit;
    item.last_round = last;
    if ($urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
      while ($urandom_range(99) < idle_pct) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= item;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    if (round_proves_composite(cand, wit)) sticky_composite = 1'b1;
    verdict.composite = sticky_composite;
    verdict.run_end   = last;
    verdict_q = {verdict_q, verdict};
    if (last) sticky_composite = 1'b0;
  endtask

  always @(posedge clk_i) begin
    if (rst_ni) out_stall_i <= ($urandom_range(99) < stall_pct);
  end

  always @(posedge clk_i) begin
    mrpt_out_t exp_v;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (verdict_q.size() == 0) begin
        $error("Unexpected transaction: composite=%0b run_end=%0b",
               out_data_o.composite, out_data_o.run_end);
        errors++;
      end else begin
        exp_v = verdict_q.pop_front();
        if (out_data_o.composite !== exp_v.composite) begin
          $error("composite: expected %0b, actual %0b", exp_v.composite,
                 out_data_o.composite);
          errors++;
        end
        if (out_data_o.run_end !== exp_v.run_end) begin
          $error("run_end: expected %0b, actual %0b", exp_v.run_end, out_data_o.run_end);
          errors++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  task automatic test_special_cases();
    send_round(32'd0, 32'd5, 1'b1);
    send_round(32'd1, 32'd0, 1'b1);
    send_round(32'd2, 32'd7, 1'b1);
    send_round(32'd4, 32'd3, 1'b1);
    send_round(32'hFFFF_FFFE, 32'hFFFF_FFFF, 1'b1);
    send_round(32'd3, 32'd6, 1'b1);
    send_round(32'd3, 32'd0, 1'b1);
    send_round(32'd65537, 32'd196611, 1'b1);
    send_round(32'hFFFF_FFFF, 32'hFFFF_FFFE, 1'b1);
    send_round(32'd9, 32'd2, 1'b0);
    send_round(32'd7, 32'd3, 1'b1);
  endtask

  task automatic test_known_runs();
    send_round(32'd4294967291, 32'hFFFF_FFFF, 1'b0);
    send_round(32'd4294967291, 32'd2, 1'b1);
    send_round(32'd2147483647, 32'd3, 1'b1);
    send_round(32'd561, 32'd2, 1'b1);
    send_round(32'd25326001, 32'd2, 1'b0);
    send_round(32'd25326001, 32'd3, 1'b0);
    send_round(32'd25326001, 32'd5, 1'b0);
    send_round(32'd25326001, 32'd7, 1'b1);
    send_round(32'd7919, 32'd1, 1'b0);
    send_round(32'd7919, 32'd7918, 1'b1);
  endtask

  task automatic test_random_runs(int unsigned runs);
    logic [31:0] primes[6] = '{32'd4294967291, 32'd2147483647, 32'd65537,
                               32'd7919, 32'd1000003, 32'd3};
    logic [31:0] cand, wit;
    int unsigned len, kind;
    for (int r = 0; r < runs; r++) begin
      kind = $urandom_range(9);
      len  = $urandom_range(1, 4);
      if (kind < 3) cand = primes[$urandom_range(5)];
      else if (kind < 7) cand = $urandom() | 32'd1;
      else if (kind < 8) cand = $urandom_range(3, 100000) | 32'd1;
      else cand = (kind == 8) ? ($urandom() & ~32'd1) : $urandom_range(2);
      for (int k = 0; k < len; k++) begin
        if ($urandom_range(4) == 0) wit = cand * $urandom_range(0, 200);
        else wit = $urandom();
        send_round(cand, wit, (k == len - 1) ? 1'b1 : ($urandom_range(15) == 0));
      end
    end
  endtask

  initial begin
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    in_data_i   = '0;
    out_stall_i = 1'b0;
    sticky_composite = 1'b0;
    idle_pct  = 0;
    stall_pct = 0;
    errors    = 0;
    cycles    = 0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_special_cases();
    test_known_runs();
    test_random_runs(8);
    idle_pct = 62;
    test_random_runs(8);
    idle_pct  = 0;
    stall_pct = 62;
    test_random_runs(8);
    idle_pct  = 26;
    stall_pct = 26;
    test_random_runs(8);
    in_valid_i <= 1'b0;
    while (verdict_q.size() != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
    if (errors == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end
endmodule
